// ===== hw/rtl/tcp_pkg.sv =====
// Shared types, register indexes and constants for the ternary chemical potential block.
`default_nettype none

package tcp_pkg;

    localparam int NUM_STAGES = 14;

    localparam int IDX_W  = 3;
    localparam int COEF_W = 24;
    localparam int LAM6_W = 27;
    localparam int FRAC_W = 16;
    localparam int MU_W   = 32;

    // Register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_GAMMA_ONE       = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAMMA_TWO       = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAMMA_THREE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_INV_GAMMA_ONE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_INV_GAMMA_TWO   = 3'd4;
    localparam logic [IDX_W-1:0] REG_INV_GAMMA_THREE = 3'd5;
    localparam logic [IDX_W-1:0] REG_TRIPLE_COUPLING = 3'd6;
    localparam logic [IDX_W-1:0] REG_OUTPUT_SCALE    = 3'd7;

    // 1.0 in Q2.14, one bit wider than the widest fraction term
    localparam logic signed [18:0] ONE_Q14 = 19'sd16384;

    // Coefficients as the datapath sees them; lambda is kept premultiplied by six
    typedef struct packed {
        logic signed [COEF_W-1:0] gamma_one;
        logic signed [COEF_W-1:0] gamma_two;
        logic signed [COEF_W-1:0] gamma_three;
        logic signed [COEF_W-1:0] inv_one;
        logic signed [COEF_W-1:0] inv_two;
        logic signed [COEF_W-1:0] inv_three;
        logic signed [LAM6_W-1:0] lam6;
        logic signed [COEF_W-1:0] scale;
    } coef_t;

    localparam coef_t COEF_RESET = '{
        gamma_one:   24'sd65536,
        gamma_two:   24'sd65536,
        gamma_three: 24'sd65536,
        inv_one:     24'sd65536,
        inv_two:     24'sd65536,
        inv_three:   24'sd65536,
        lam6:        27'sd0,
        scale:       24'sd65536
    };

endpackage

`default_nettype wire

// ===== hw/rtl/ternary_chemical_potential.sv =====
// Top level: coefficient registers and the chemical potential pipeline.
//
// Usage:
//   Input channel (frac_valid / frac_stall) carries one grid point per item:
//   the Q2.14 phase fractions frac_one and frac_two. An item is taken at a
//   clock edge with frac_valid high and frac_stall low.
//   Output channel (mu_valid / mu_stall) returns one item per input item:
//   the saturated Q16.16 potentials mu_one and mu_two, in input order.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   one 24-bit Q8.16 coefficient per handshake; cfg_ready is always high.
//   Write coefficients only while no item is in flight.
// Timing:
//   Each item passes through the fourteen register stages of the multiply and
//   round chain. Throughput is one item per cycle while mu_stall is low.
// Reset:
//   rst_n clears all stage valid bits and loads the coefficient defaults
//   (gammas, reciprocals and scale 1.0, coupling 0).
// Backpressure:
//   When mu_stall holds a valid result, the pipeline keeps filling its empty
//   stages; frac_stall rises only once every stage holds an item.
`default_nettype none

module ternary_chemical_potential (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                frac_valid,
    output logic                                     frac_stall,
    input  wire logic signed [tcp_pkg::FRAC_W-1:0]   frac_one,
    input  wire logic signed [tcp_pkg::FRAC_W-1:0]   frac_two,
    output logic                                     mu_valid,
    input  wire logic                                mu_stall,
    output logic signed [tcp_pkg::MU_W-1:0]          mu_one,
    output logic signed [tcp_pkg::MU_W-1:0]          mu_two,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [tcp_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic signed [tcp_pkg::COEF_W-1:0]   cfg_data
);

    tcp_pkg::coef_t coef_reg;
    tcp_pkg::coef_t coef_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcp_pkg::REG_GAMMA_ONE:       coef_next.gamma_one   = cfg_data;
                tcp_pkg::REG_GAMMA_TWO:       coef_next.gamma_two   = cfg_data;
                tcp_pkg::REG_GAMMA_THREE:     coef_next.gamma_three = cfg_data;
                tcp_pkg::REG_INV_GAMMA_ONE:   coef_next.inv_one     = cfg_data;
                tcp_pkg::REG_INV_GAMMA_TWO:   coef_next.inv_two     = cfg_data;
                tcp_pkg::REG_INV_GAMMA_THREE: coef_next.inv_three   = cfg_data;
                // store 6*lambda as 4x + 2x
                tcp_pkg::REG_TRIPLE_COUPLING:
                begin
                    coef_next.lam6 = {cfg_data[23], cfg_data, 2'b00}
                                   + {{2{cfg_data[23]}}, cfg_data, 1'b0};
                end
                tcp_pkg::REG_OUTPUT_SCALE:    coef_next.scale       = cfg_data;
                default:                      coef_next             = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= tcp_pkg::COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    tcp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frac_valid),
        .in_stall  (frac_stall),
        .frac_one  (frac_one),
        .frac_two  (frac_two),
        .coef      (coef_reg),
        .out_valid (mu_valid),
        .out_stall (mu_stall),
        .mu_one    (mu_one),
        .mu_two    (mu_two)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tcp_datapath.sv =====
// Fourteen-stage fixed-point pipeline for the ternary chemical potential.
`default_nettype none

module tcp_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [tcp_pkg::FRAC_W-1:0]   frac_one,
    input  wire logic signed [tcp_pkg::FRAC_W-1:0]   frac_two,
    input  wire tcp_pkg::coef_t                      coef,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [tcp_pkg::MU_W-1:0]          mu_one,
    output logic signed [tcp_pkg::MU_W-1:0]          mu_two
);

    localparam int N = tcp_pkg::NUM_STAGES;
    localparam logic [N-1:0] STG_ONE = N'(1);

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N-1:0] adv;

    // Stage 1: fractions and the factors (1-c), (1-2c)
    logic signed [17:0] s1_c_next [3];
    logic signed [17:0] s1_a_next [3];
    logic signed [18:0] s1_b_next [3];
    logic signed [17:0] s1_c_reg  [3];
    logic signed [17:0] s1_a_reg  [3];
    logic signed [18:0] s1_b_reg  [3];

    // Stage 2: c*(1-c) and the pair products
    logic signed [33:0] s2_ca_next   [3];
    logic signed [32:0] s2_pair_next [3];
    logic signed [33:0] s2_ca_reg    [3];
    logic signed [32:0] s2_pair_reg  [3];
    logic signed [18:0] s2_b_reg     [3];
    logic signed [17:0] s2_c3_reg;

    // Stage 3: cubic products, triple product, rounded pairs
    logic signed [50:0] s3_cab_next [3];
    logic signed [47:0] s3_t_next;
    logic signed [20:0] s3_pr_next  [3];
    logic signed [50:0] s3_cab_reg  [3];
    logic signed [47:0] s3_t_reg;
    logic signed [20:0] s3_pr_reg   [3];

    // Stage 4: rounded cubic terms and triple product
    logic signed [24:0] s4_cub_next [3];
    logic signed [21:0] s4_triple_next;
    logic signed [24:0] s4_cub_reg  [3];
    logic signed [21:0] s4_triple_reg;
    logic signed [20:0] s4_pr_reg   [3];

    // Stage 5: gamma*f and triple*pair
    logic signed [47:0] s5_gf_next [3];
    logic signed [40:0] s5_tp_next [3];
    logic signed [47:0] s5_gf_reg  [3];
    logic signed [40:0] s5_tp_reg  [3];

    // Stage 6: rounded coupling
    logic signed [24:0] s6_cpl_next [3];
    logic signed [24:0] s6_cpl_reg  [3];
    logic signed [47:0] s6_gf_reg   [3];

    // Stage 7: 6*lambda*coupling
    logic signed [50:0] s7_lc_next [3];
    logic signed [50:0] s7_lc_reg  [3];
    logic signed [47:0] s7_gf_reg  [3];

    // Stage 8: G values
    logic signed [51:0] s8_g_next [3];
    logic signed [51:0] s8_g_reg  [3];

    // Stage 9: rounded differences (g1-g2, g1-g3, g2-g1, g2-g3)
    logic signed [35:0] s9_d_next [4];
    logic signed [35:0] s9_d_reg  [4];

    // Stage 10: differences times reciprocals
    logic signed [58:0] s10_e_next [4];
    logic signed [58:0] s10_e_reg  [4];

    // Stage 11: rounded sums
    logic signed [43:0] s11_s_next [2];
    logic signed [43:0] s11_s_reg  [2];

    // Stage 12: scale multiply, split into high and low halves
    logic signed [51:0] s12_mh_next [2];
    logic signed [39:0] s12_ml_next [2];
    logic signed [51:0] s12_mh_reg  [2];
    logic signed [39:0] s12_ml_reg  [2];

    // Stage 13: recombined scaled value
    logic signed [52:0] s13_r_next [2];
    logic signed [52:0] s13_r_reg  [2];

    // Stage 14: saturated output
    logic signed [31:0] s14_mu_next [2];
    logic signed [31:0] s14_mu_reg  [2];

    // ------------------------------------------------------------------
    // Flow control: a stage moves when it is empty or the one after moves
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            adv[k] = !(out_stall && (&(vld_reg | ((STG_ONE << k) - STG_ONE))));
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < N; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[N-1];
    assign mu_one    = s14_mu_reg[0];
    assign mu_two    = s14_mu_reg[1];

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [18:0] c1;
        logic signed [18:0] c2;
        logic signed [18:0] c3;
        logic signed [18:0] c12;
        c1  = {{3{frac_one[15]}}, frac_one};
        c2  = {{3{frac_two[15]}}, frac_two};
        c12 = c1 + c2;
        c3  = tcp_pkg::ONE_Q14 - c12;
        s1_c_next[0] = c1[17:0];
        s1_c_next[1] = c2[17:0];
        s1_c_next[2] = c3[17:0];
        s1_a_next[0] = 18'(tcp_pkg::ONE_Q14 - c1);
        s1_a_next[1] = 18'(tcp_pkg::ONE_Q14 - c2);
        // 1 - c3 is c1 + c2
        s1_a_next[2] = c12[17:0];
        s1_b_next[0] = tcp_pkg::ONE_Q14 - {c1[17:0], 1'b0};
        s1_b_next[1] = tcp_pkg::ONE_Q14 - {c2[17:0], 1'b0};
        s1_b_next[2] = {c12[17:0], 1'b0} - tcp_pkg::ONE_Q14;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_c_reg <= s1_c_next;
            s1_a_reg <= s1_a_next;
            s1_b_reg <= s1_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [35:0] ca_full   [3];
        logic signed [35:0] pair_full [3];
        for (int i = 0; i < 3; i++)
        begin
            ca_full[i]    = s1_c_reg[i] * s1_a_reg[i];
            s2_ca_next[i] = ca_full[i][33:0];
        end
        pair_full[0] = s1_c_reg[1] * s1_c_reg[2];
        pair_full[1] = s1_c_reg[0] * s1_c_reg[2];
        pair_full[2] = s1_c_reg[0] * s1_c_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            s2_pair_next[i] = pair_full[i][32:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_ca_reg   <= s2_ca_next;
            s2_pair_reg <= s2_pair_next;
            s2_b_reg    <= s1_b_reg;
            s2_c3_reg   <= s1_c_reg[2];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [52:0] cab_full [3];
        logic signed [50:0] t_full;
        logic        [33:0] pr_sum   [3];
        for (int i = 0; i < 3; i++)
        begin
            cab_full[i]    = s2_ca_reg[i] * s2_b_reg[i];
            s3_cab_next[i] = cab_full[i][50:0];
            pr_sum[i]      = {s2_pair_reg[i][32], s2_pair_reg[i]} + 34'd2048;
            s3_pr_next[i]  = pr_sum[i][32:12];
        end
        // c1*c2 is the third pair product
        t_full    = s2_pair_reg[2] * s2_c3_reg;
        s3_t_next = t_full[47:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_cab_reg <= s3_cab_next;
            s3_t_reg   <= s3_t_next;
            s3_pr_reg  <= s3_pr_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [51:0] cub_sum [3];
        logic [48:0] t_sum;
        for (int i = 0; i < 3; i++)
        begin
            cub_sum[i]     = {s3_cab_reg[i][50], s3_cab_reg[i]} + 52'd33554432;
            s4_cub_next[i] = cub_sum[i][50:26];
        end
        t_sum          = {s3_t_reg[47], s3_t_reg} + 49'd33554432;
        s4_triple_next = t_sum[47:26];
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_cub_reg    <= s4_cub_next;
            s4_triple_reg <= s4_triple_next;
            s4_pr_reg     <= s3_pr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [23:0] gamma   [3];
        logic signed [48:0] gf_full [3];
        logic signed [42:0] tp_full [3];
        gamma[0] = coef.gamma_one;
        gamma[1] = coef.gamma_two;
        gamma[2] = coef.gamma_three;
        for (int i = 0; i < 3; i++)
        begin
            gf_full[i]    = gamma[i] * s4_cub_reg[i];
            s5_gf_next[i] = gf_full[i][47:0];
            tp_full[i]    = s4_triple_reg * s4_pr_reg[i];
            s5_tp_next[i] = tp_full[i][40:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_gf_reg <= s5_gf_next;
            s5_tp_reg <= s5_tp_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [41:0] cpl_sum [3];
        for (int i = 0; i < 3; i++)
        begin
            cpl_sum[i]     = {s5_tp_reg[i][40], s5_tp_reg[i]} + 42'd32768;
            s6_cpl_next[i] = cpl_sum[i][40:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_cpl_reg <= s6_cpl_next;
            s6_gf_reg  <= s5_gf_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [51:0] lc_full [3];
        for (int i = 0; i < 3; i++)
        begin
            lc_full[i]    = coef.lam6 * s6_cpl_reg[i];
            s7_lc_next[i] = lc_full[i][50:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s7_lc_reg <= s7_lc_next;
            s7_gf_reg <= s6_gf_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s8_g_next[i] = {{4{s7_gf_reg[i][47]}}, s7_gf_reg[i]}
                         + {s7_lc_reg[i][50], s7_lc_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s8_g_reg <= s8_g_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: each difference rounds on its own, so g2-g1 is not -(g1-g2)
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [52:0] g_ext [3];
        logic [52:0] d_sum [4];
        for (int i = 0; i < 3; i++)
        begin
            g_ext[i] = {s8_g_reg[i][51], s8_g_reg[i]};
        end
        d_sum[0] = g_ext[0] - g_ext[1] + 53'd32768;
        d_sum[1] = g_ext[0] - g_ext[2] + 53'd32768;
        d_sum[2] = g_ext[1] - g_ext[0] + 53'd32768;
        d_sum[3] = g_ext[1] - g_ext[2] + 53'd32768;
        for (int i = 0; i < 4; i++)
        begin
            s9_d_next[i] = d_sum[i][51:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s9_d_reg <= s9_d_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [23:0] inv    [4];
        logic signed [59:0] e_full [4];
        inv[0] = coef.inv_two;
        inv[1] = coef.inv_three;
        inv[2] = coef.inv_one;
        inv[3] = coef.inv_three;
        for (int i = 0; i < 4; i++)
        begin
            e_full[i]     = s9_d_reg[i] * inv[i];
            s10_e_next[i] = e_full[i][58:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            s10_e_reg <= s10_e_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [59:0] s_sum [2];
        for (int j = 0; j < 2; j++)
        begin
            s_sum[j] = {s10_e_reg[2*j][58], s10_e_reg[2*j]}
                     + {s10_e_reg[2*j+1][58], s10_e_reg[2*j+1]}
                     + 60'd32768;
            s11_s_next[j] = s_sum[j][59:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            s11_s_reg <= s11_s_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: s*scale as floor(s/2^16)*scale plus the low half apart
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [27:0] hi      [2];
        logic signed [16:0] lo      [2];
        logic signed [40:0] ml_full [2];
        for (int j = 0; j < 2; j++)
        begin
            hi[j]          = s11_s_reg[j][43:16];
            lo[j]          = $signed({1'b0, s11_s_reg[j][15:0]});
            s12_mh_next[j] = hi[j] * coef.scale;
            ml_full[j]     = lo[j] * coef.scale;
            s12_ml_next[j] = ml_full[j][39:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[11])
        begin
            s12_mh_reg <= s12_mh_next;
            s12_ml_reg <= s12_ml_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 13
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [40:0] ml_sum [2];
        logic [23:0] ml_rnd [2];
        for (int j = 0; j < 2; j++)
        begin
            ml_sum[j]     = {s12_ml_reg[j][39], s12_ml_reg[j]} + 41'd32768;
            ml_rnd[j]     = ml_sum[j][39:16];
            s13_r_next[j] = {s12_mh_reg[j][51], s12_mh_reg[j]}
                          + {{29{ml_rnd[j][23]}}, ml_rnd[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[12])
        begin
            s13_r_reg <= s13_r_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 14: saturate to 32 bits
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            if (s13_r_reg[j] > 53'sd2147483647)
            begin
                s14_mu_next[j] = 32'sh7fffffff;
            end
            else if (s13_r_reg[j] < -53'sd2147483648)
            begin
                s14_mu_next[j] = 32'sh80000000;
            end
            else
            begin
                s14_mu_next[j] = s13_r_reg[j][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[13])
        begin
            s14_mu_reg <= s14_mu_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcp_checker.sv =====
// Port-level checks for the ternary chemical potential block, bound to the top level.
`default_nettype none

module tcp_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               frac_stall,
    input wire logic                               mu_valid,
    input wire logic                               mu_stall,
    input wire logic signed [tcp_pkg::MU_W-1:0]    mu_one,
    input wire logic signed [tcp_pkg::MU_W-1:0]    mu_two
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mu_valid && mu_stall |=> mu_valid && $stable(mu_one) && $stable(mu_two))
        else $error("stalled output item changed");

    // Input backs up only when the output is full and stalled
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        frac_stall |-> mu_valid && mu_stall)
        else $error("input stalled while output side could drain");

    // Leaving reset, the pipeline is empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !mu_valid && !frac_stall)
        else $error("pipeline not empty after reset");

endmodule

bind ternary_chemical_potential tcp_checker u_tcp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .frac_stall (frac_stall),
    .mu_valid   (mu_valid),
    .mu_stall   (mu_stall),
    .mu_one     (mu_one),
    .mu_two     (mu_two)
);

`default_nettype wire
